@@ design/rrrq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrrq_pkg
// Shared constants and controller/datapath interface types for the
// round-robin ready queue.
// ----------------------------------------------------------------------------
package rrrq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    localparam int ID_W      = 8;
    localparam int BURST_W   = 16;
    localparam int QUANTUM_W = 8;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd4;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    typedef struct packed {
        logic capture;
        logic mem_read;
        logic execute;
    } rrrq_cmd_t;

    typedef struct packed {
        logic out_busy;
    } rrrq_status_t;

endpackage
`default_nettype wire

@@ design/rrrq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrrq_ctrl
// Sequencer: take request, read head entry, execute when the result
// register is free.
// ----------------------------------------------------------------------------
module rrrq_ctrl
    import rrrq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire rrrq_status_t status,
    output rrrq_cmd_t         cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                if (!status.out_busy)
                begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ design/rrrq_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrrq_dpath
// Task store, head/tail pointers, occupancy, quantum charge and result
// register.
// ----------------------------------------------------------------------------
module rrrq_dpath
    import rrrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rrrq_cmd_t            cmd,
    output rrrq_status_t              status,
    input  wire logic                 quantum_we,
    input  wire logic [QUANTUM_W-1:0] quantum_wdata,
    input  wire logic                 opcode,
    input  wire logic [ID_W-1:0]      task_id,
    input  wire logic [BURST_W-1:0]   burst_time,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [ID_W-1:0]           ran_id,
    output logic [QUANTUM_W-1:0]      time_run,
    output logic [BURST_W-1:0]        time_left,
    output logic                      finished,
    output logic                      none_ready,
    output logic                      queue_full
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_W + BURST_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

    logic                 op_reg;
    logic [ID_W-1:0]      id_in_reg;
    logic [BURST_W-1:0]   burst_in_reg;
    logic [QUANTUM_W-1:0] quantum_reg;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [ENTRY_W-1:0]   rd_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [ID_W-1:0]      ran_id_reg, ran_id_next;
    logic [QUANTUM_W-1:0] time_run_reg, time_run_next;
    logic [BURST_W-1:0]   time_left_reg, time_left_next;
    logic                 finished_reg, finished_next;
    logic                 none_ready_reg, none_ready_next;
    logic                 queue_full_reg, queue_full_next;

    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_data;

    logic                 q_full;
    logic                 q_empty;
    logic [ID_W-1:0]      rd_id;
    logic [BURST_W-1:0]   rd_burst;
    logic [BURST_W-1:0]   quantum_ext;
    logic [BURST_W-1:0]   charge;
    logic [BURST_W-1:0]   left;

    assign q_full      = (occ_reg == FULL_OCC);
    assign q_empty     = (occ_reg == '0);
    assign rd_id       = rd_reg[ENTRY_W-1:BURST_W];
    assign rd_burst    = rd_reg[BURST_W-1:0];
    assign quantum_ext = BURST_W'(quantum_reg);
    assign charge      = (rd_burst < quantum_ext) ? rd_burst : quantum_ext;
    assign left        = rd_burst - charge;

    assign status.out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        wr_en           = 1'b0;
        wr_data         = {id_in_reg, burst_in_reg};
        ran_id_next     = ran_id_reg;
        time_run_next   = time_run_reg;
        time_left_next  = time_left_reg;
        finished_next   = finished_reg;
        none_ready_next = none_ready_reg;
        queue_full_next = queue_full_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.execute)
        begin
            out_valid_next  = 1'b1;
            ran_id_next     = '0;
            time_run_next   = '0;
            time_left_next  = '0;
            finished_next   = 1'b0;
            none_ready_next = 1'b0;
            queue_full_next = 1'b0;
            if (op_reg == OP_ADMIT)
            begin
                if (q_full)
                begin
                    queue_full_next = 1'b1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            else if (q_empty)
            begin
                none_ready_next = 1'b1;
            end
            else
            begin
                head_next      = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                ran_id_next    = rd_id;
                time_run_next  = charge[QUANTUM_W-1:0];
                time_left_next = left;
                if (left == '0)
                begin
                    finished_next = 1'b1;
                    occ_next      = occ_reg - 1'b1;
                end
                else
                begin
                    // requeue at tail; the dequeue freed a slot
                    wr_en     = 1'b1;
                    wr_data   = {rd_id, left};
                    tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= wr_data;
        end
        if (cmd.mem_read)
        begin
            rd_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            id_in_reg    <= task_id;
            burst_in_reg <= burst_time;
        end
        ran_id_reg    <= ran_id_next;
        time_run_reg  <= time_run_next;
        time_left_reg <= time_left_next;
        finished_reg  <= finished_next;
        none_ready_reg <= none_ready_next;
        queue_full_reg <= queue_full_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            quantum_reg   <= QUANTUM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (quantum_we)
            begin
                quantum_reg <= quantum_wdata;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign ran_id     = ran_id_reg;
    assign time_run   = time_run_reg;
    assign time_left  = time_left_reg;
    assign finished   = finished_reg;
    assign none_ready = none_ready_reg;
    assign queue_full = queue_full_reg;

endmodule
`default_nettype wire

@@ design/round_robin_ready_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_ready_queue
// Round-robin ready queue: admit tasks at the tail, run the head task for
// up to one quantum and requeue it until its burst is spent.
//
// Input channel (in_valid/in_stall) carries one request: opcode, task_id,
// burst_time. Every request yields exactly one result on the output
// channel (out_valid/out_stall): ran_id, time_run, time_left, finished,
// none_ready, queue_full.
// A request passes through the sequencer's capture, store read and execute
// steps; the block takes no new request until the previous one has executed.
// The task store has one read port and one write port.
// A waiting result does not block acceptance of the next request; that
// request's execute step waits while the result register is stalled.
// The user must write quantum through quantum_we/quantum_wdata only while idle; the block itself does not enforce it.
// Reset empties the queue and sets quantum to 4; the task store itself is
// not cleared.
// ----------------------------------------------------------------------------
module round_robin_ready_queue
    import rrrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 quantum_we,
    input  wire logic [QUANTUM_W-1:0] quantum_wdata,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 opcode,
    input  wire logic [ID_W-1:0]      task_id,
    input  wire logic [BURST_W-1:0]   burst_time,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [ID_W-1:0]           ran_id,
    output logic [QUANTUM_W-1:0]      time_run,
    output logic [BURST_W-1:0]        time_left,
    output logic                      finished,
    output logic                      none_ready,
    output logic                      queue_full
);

    rrrq_cmd_t    cmd;
    rrrq_status_t status;

    rrrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rrrq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .quantum_we    (quantum_we),
        .quantum_wdata (quantum_wdata),
        .opcode        (opcode),
        .task_id       (task_id),
        .burst_time    (burst_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ran_id        (ran_id),
        .time_run      (time_run),
        .time_left     (time_left),
        .finished      (finished),
        .none_ready    (none_ready),
        .queue_full    (queue_full)
    );

endmodule
`default_nettype wire
